// ===== hw/rtl/slpm_pkg.sv =====
// ----------------------------------------------------------------------------
// slpm_pkg
// Shared constants, register codes and stage types of the serpentine LED
// panel mapper.
// ----------------------------------------------------------------------------
package slpm_pkg;

  localparam int MAX_LEDS      = 4096;
  localparam int BITMAP_DIM    = 256;
  localparam int MAX_PANEL_DIM = 64;

  // Fixed field widths.
  localparam int PIX_W   = 8;
  localparam int COLOR_W = 8;
  localparam int BASE_W  = 12;
  localparam int SIZE_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Widths that follow from the limits.
  localparam int DIM_W   = $clog2(MAX_PANEL_DIM + 1);
  localparam int COORD_W = $clog2(MAX_PANEL_DIM);
  localparam int LED_W   = $clog2(MAX_LEDS);
  localparam int PROD_W  = COORD_W + DIM_W;
  localparam int SUM_W   = ((LED_W > PROD_W) ? LED_W : PROD_W) + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_BASE      = 3'd0,
    REG_PANEL_LEFT    = 3'd1,
    REG_PANEL_TOP     = 3'd2,
    REG_PANEL_WIDTH   = 3'd3,
    REG_PANEL_HEIGHT  = 3'd4,
    REG_WRAP_MODE     = 3'd5,
    REG_ORIGIN_CORNER = 3'd6
  } reg_idx_t;

  typedef enum logic {
    WRAP_ROWS = 1'b0,
    WRAP_COLS = 1'b1
  } wrap_t;

  typedef enum logic [1:0] {
    CORNER_TL = 2'd0,
    CORNER_TR = 2'd1,
    CORNER_BR = 2'd2,
    CORNER_BL = 2'd3
  } corner_t;

  typedef struct packed {
    logic [BASE_W-1:0] led_base;
    logic [PIX_W-1:0]  panel_left;
    logic [PIX_W-1:0]  panel_top;
    logic [SIZE_W-1:0] panel_width;
    logic [SIZE_W-1:0] panel_height;
    wrap_t             wrap_mode;
    corner_t           origin_corner;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic               win_hit;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    rgb_t               rgb;
  } s1_t;

  typedef struct packed {
    logic              win_hit;
    logic [PROD_W-1:0] pos;
    rgb_t              rgb;
  } s3_t;

endpackage

// ===== hw/rtl/slpm_cfg.sv =====
// ----------------------------------------------------------------------------
// slpm_cfg
// Configuration register file of the panel mapper.
// ----------------------------------------------------------------------------
module slpm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [slpm_pkg::CFG_IDX_W-1:0]   wr_idx,
  input  logic [slpm_pkg::CFG_DATA_W-1:0]  wr_data,
  output slpm_pkg::cfg_t                   cfg
);

  slpm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_base      <= '0;
      cfg_r.panel_left    <= '0;
      cfg_r.panel_top     <= '0;
      cfg_r.panel_width   <= slpm_pkg::SIZE_W'(8);
      cfg_r.panel_height  <= slpm_pkg::SIZE_W'(8);
      cfg_r.wrap_mode     <= slpm_pkg::WRAP_ROWS;
      cfg_r.origin_corner <= slpm_pkg::CORNER_TL;
    end else if (wr_en) begin
      case (wr_idx)
        slpm_pkg::REG_LED_BASE:
          cfg_r.led_base <= wr_data[slpm_pkg::BASE_W-1:0];
        slpm_pkg::REG_PANEL_LEFT:
          cfg_r.panel_left <= wr_data[slpm_pkg::PIX_W-1:0];
        slpm_pkg::REG_PANEL_TOP:
          cfg_r.panel_top <= wr_data[slpm_pkg::PIX_W-1:0];
        slpm_pkg::REG_PANEL_WIDTH:
          cfg_r.panel_width <= wr_data[slpm_pkg::SIZE_W-1:0];
        slpm_pkg::REG_PANEL_HEIGHT:
          cfg_r.panel_height <= wr_data[slpm_pkg::SIZE_W-1:0];
        slpm_pkg::REG_WRAP_MODE:
          cfg_r.wrap_mode <= slpm_pkg::wrap_t'(wr_data[0]);
        slpm_pkg::REG_ORIGIN_CORNER:
          cfg_r.origin_corner <= slpm_pkg::corner_t'(wr_data[1:0]);
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/slpm_window.sv =====
// ----------------------------------------------------------------------------
// slpm_window
// Stage 1: clamp the panel size, test the window and take panel offsets.
// ----------------------------------------------------------------------------
module slpm_window (
  input  logic                          clk,
  input  logic                          load,
  input  slpm_pkg::cfg_t                cfg,
  input  logic [slpm_pkg::PIX_W-1:0]    pixel_x,
  input  logic [slpm_pkg::PIX_W-1:0]    pixel_y,
  input  slpm_pkg::rgb_t                rgb,
  output slpm_pkg::s1_t                 s1
);

  logic [slpm_pkg::PIX_W:0]   dx;
  logic [slpm_pkg::PIX_W:0]   dy;
  logic [slpm_pkg::DIM_W-1:0] w_clamp;
  logic [slpm_pkg::DIM_W-1:0] h_clamp;
  logic                       in_bitmap;
  logic                       in_x;
  logic                       in_y;
  slpm_pkg::s1_t              s1_nxt;
  slpm_pkg::s1_t              s1_r;

  always_comb begin
    w_clamp = (32'(cfg.panel_width) > slpm_pkg::MAX_PANEL_DIM) ?
              slpm_pkg::DIM_W'(slpm_pkg::MAX_PANEL_DIM) : slpm_pkg::DIM_W'(cfg.panel_width);
    h_clamp = (32'(cfg.panel_height) > slpm_pkg::MAX_PANEL_DIM) ?
              slpm_pkg::DIM_W'(slpm_pkg::MAX_PANEL_DIM) : slpm_pkg::DIM_W'(cfg.panel_height);
    dx = {1'b0, pixel_x} - {1'b0, cfg.panel_left};
    dy = {1'b0, pixel_y} - {1'b0, cfg.panel_top};
    in_bitmap = (32'(pixel_x) < slpm_pkg::BITMAP_DIM) && (32'(pixel_y) < slpm_pkg::BITMAP_DIM);
    // borrow out means the pixel lies left of or above the window
    in_x = !dx[slpm_pkg::PIX_W] && (32'(dx[slpm_pkg::PIX_W-1:0]) < 32'(w_clamp));
    in_y = !dy[slpm_pkg::PIX_W] && (32'(dy[slpm_pkg::PIX_W-1:0]) < 32'(h_clamp));
    s1_nxt.win_hit = in_bitmap && in_x && in_y;
    s1_nxt.cx      = dx[slpm_pkg::COORD_W-1:0];
    s1_nxt.cy      = dy[slpm_pkg::COORD_W-1:0];
    s1_nxt.w       = w_clamp;
    s1_nxt.h       = h_clamp;
    s1_nxt.rgb     = rgb;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

// ===== hw/rtl/slpm_index.sv =====
// ----------------------------------------------------------------------------
// slpm_index
// Stages 2 and 3: orient to the origin corner, pick the serpentine axis,
// then form the offset inside the panel.
// ----------------------------------------------------------------------------
module slpm_index (
  input  logic            clk,
  input  slpm_pkg::adv_t  adv,
  input  slpm_pkg::cfg_t  cfg,
  input  slpm_pkg::s1_t   s1,
  output slpm_pkg::s3_t   s3
);

  typedef struct packed {
    logic                         win_hit;
    logic [slpm_pkg::COORD_W-1:0] major;
    logic [slpm_pkg::COORD_W-1:0] minor;
    logic [slpm_pkg::DIM_W-1:0]   len;
    slpm_pkg::rgb_t               rgb;
  } s2_t;

  logic [slpm_pkg::DIM_W-1:0]   w_m1;
  logic [slpm_pkg::DIM_W-1:0]   h_m1;
  logic [slpm_pkg::COORD_W-1:0] cx_o;
  logic [slpm_pkg::COORD_W-1:0] cy_o;
  logic                         flip_x;
  logic                         flip_y;
  s2_t                          s2_nxt;
  s2_t                          s2_r;
  slpm_pkg::s3_t                s3_nxt;
  slpm_pkg::s3_t                s3_r;

  // stage 2: corner orientation and serpentine reversal
  always_comb begin
    w_m1   = s1.w - slpm_pkg::DIM_W'(1);
    h_m1   = s1.h - slpm_pkg::DIM_W'(1);
    flip_x = (cfg.origin_corner == slpm_pkg::CORNER_TR) ||
             (cfg.origin_corner == slpm_pkg::CORNER_BR);
    flip_y = (cfg.origin_corner == slpm_pkg::CORNER_BR) ||
             (cfg.origin_corner == slpm_pkg::CORNER_BL);
    cx_o = flip_x ? slpm_pkg::COORD_W'(w_m1 - slpm_pkg::DIM_W'(s1.cx)) : s1.cx;
    cy_o = flip_y ? slpm_pkg::COORD_W'(h_m1 - slpm_pkg::DIM_W'(s1.cy)) : s1.cy;
    s2_nxt.win_hit = s1.win_hit;
    s2_nxt.rgb     = s1.rgb;
    unique case (cfg.wrap_mode)
      slpm_pkg::WRAP_ROWS: begin
        s2_nxt.major = cy_o;
        s2_nxt.len   = s1.w;
        s2_nxt.minor = cy_o[0] ? slpm_pkg::COORD_W'(w_m1 - slpm_pkg::DIM_W'(cx_o)) : cx_o;
      end
      slpm_pkg::WRAP_COLS: begin
        s2_nxt.major = cx_o;
        s2_nxt.len   = s1.h;
        s2_nxt.minor = cx_o[0] ? slpm_pkg::COORD_W'(h_m1 - slpm_pkg::DIM_W'(cy_o)) : cy_o;
      end
      default: begin
        s2_nxt.major = cy_o;
        s2_nxt.len   = s1.w;
        s2_nxt.minor = cx_o;
      end
    endcase
  end

  // stage 3: line number times line length plus position in the line
  always_comb begin
    s3_nxt.win_hit = s2_r.win_hit;
    s3_nxt.rgb     = s2_r.rgb;
    s3_nxt.pos     = slpm_pkg::PROD_W'(s2_r.major) * slpm_pkg::PROD_W'(s2_r.len) +
                     slpm_pkg::PROD_W'(s2_r.minor);
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_r <= s2_nxt;
    end
    if (adv.s3) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

// ===== hw/rtl/serpentine_led_panel_mapper.sv =====
// ----------------------------------------------------------------------------
// serpentine_led_panel_mapper
// Maps a bitmap pixel to the strip index of one zigzag-wired LED panel.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_ channel (in_valid / in_stall) with their bitmap
//   coordinates and color. Each pixel gives exactly one result beat on the
//   out_ channel (out_valid / out_stall): the LED index, the color and hit.
//   A miss (outside the window or past the LED store) returns all zeros.
//   Panel geometry is set through the cfg_ write port, always ready; write
//   it only while no pixel is in flight.
//   A beat passes through registered stages from input to output: window
//   test, corner and serpentine orientation, multiply-add of the panel
//   offset, then the base add and range check in the output register.
//   Throughput is one pixel per clock while out_stall is low; the multiply
//   stage bounds the clock. When the receiver stalls, stages fill up behind
//   the output register and in_stall rises only once every stage holds a
//   beat; bubbles collapse. Reset (rst_n low, synchronous) empties the
//   pipeline and loads the register defaults: an 8 by 8 panel at the
//   bitmap origin, base 0, row-wise wiring from the top-left corner.
// ----------------------------------------------------------------------------
module serpentine_led_panel_mapper (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [slpm_pkg::PIX_W-1:0]       in_pixel_x,
  input  logic [slpm_pkg::PIX_W-1:0]       in_pixel_y,
  input  logic [slpm_pkg::COLOR_W-1:0]     in_red_in,
  input  logic [slpm_pkg::COLOR_W-1:0]     in_green_in,
  input  logic [slpm_pkg::COLOR_W-1:0]     in_blue_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [slpm_pkg::BASE_W-1:0]      out_led_index,
  output logic [slpm_pkg::COLOR_W-1:0]     out_red_out,
  output logic [slpm_pkg::COLOR_W-1:0]     out_green_out,
  output logic [slpm_pkg::COLOR_W-1:0]     out_blue_out,
  output logic                             out_hit,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  slpm_pkg::cfg_t cfg;
  slpm_pkg::adv_t adv;
  slpm_pkg::rgb_t in_rgb;
  slpm_pkg::s1_t  s1;
  slpm_pkg::s3_t  s3;

  logic v1_r;
  logic v2_r;
  logic v3_r;
  logic v4_r;
  logic rdy1;
  logic rdy2;
  logic rdy3;
  logic rdy4;
  logic load4;

  logic [slpm_pkg::SUM_W-1:0]   idx_sum;
  logic                         hit_nxt;
  logic [slpm_pkg::BASE_W-1:0]  led_index_r;
  slpm_pkg::rgb_t               rgb_r;
  logic                         hit_r;

  assign cfg_ready = 1'b1;

  slpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // A stage can take a beat when it is empty or its beat moves on.
  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  assign adv.s1 = rdy1 && in_valid;
  assign adv.s2 = rdy2 && v1_r;
  assign adv.s3 = rdy3 && v2_r;
  assign load4  = rdy4 && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  assign in_rgb.red   = in_red_in;
  assign in_rgb.green = in_green_in;
  assign in_rgb.blue  = in_blue_in;

  slpm_window u_window (
    .clk     (clk),
    .load    (adv.s1),
    .cfg     (cfg),
    .pixel_x (in_pixel_x),
    .pixel_y (in_pixel_y),
    .rgb     (in_rgb),
    .s1      (s1)
  );

  slpm_index u_index (
    .clk (clk),
    .adv (adv),
    .cfg (cfg),
    .s1  (s1),
    .s3  (s3)
  );

  // Stage 4: add the strip base, check the LED store and zero a miss.
  always_comb begin
    idx_sum = slpm_pkg::SUM_W'(cfg.led_base) + slpm_pkg::SUM_W'(s3.pos);
    hit_nxt = s3.win_hit && (idx_sum < slpm_pkg::SUM_W'(slpm_pkg::MAX_LEDS));
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      hit_r       <= hit_nxt;
      led_index_r <= hit_nxt ? slpm_pkg::BASE_W'(idx_sum) : '0;
      rgb_r       <= hit_nxt ? s3.rgb : '0;
    end
  end

  assign out_valid     = v4_r;
  assign out_led_index = led_index_r;
  assign out_red_out   = rgb_r.red;
  assign out_green_out = rgb_r.green;
  assign out_blue_out  = rgb_r.blue;
  assign out_hit       = hit_r;

endmodule
